// ===== hw/rtl/kti_pkg.sv =====
package kti_pkg;

    localparam int VAL_W    = 32;
    localparam int NUM_VALS = 10;
    localparam int DUR_W    = 31;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_SAMPLE_OK = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_INSERT_OK = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    localparam logic CFG_DURATION = 1'b0;
    localparam logic CFG_LOOP     = 1'b1;

    typedef struct packed {
        logic [1:0]        cmd;
        logic signed [31:0] item_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] aim_x;
        logic signed [31:0] aim_y;
        logic signed [31:0] aim_z;
        logic signed [31:0] yaw_in;
        logic signed [31:0] pitch_in;
        logic signed [31:0] fov_in;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              finished;
        logic signed [31:0] out_time;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_aim_x;
        logic signed [31:0] out_aim_y;
        logic signed [31:0] out_aim_z;
        logic signed [31:0] out_yaw;
        logic signed [31:0] out_pitch;
        logic signed [31:0] out_fov;
    } out_word_t;

    typedef logic [NUM_VALS*VAL_W-1:0] row_t;

endpackage

// ===== hw/rtl/kti_ram.sv =====
module kti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/keyframe_track_interpolator.sv =====
// Keyframe track interpolator: sorted keyframe table in one row-wide RAM.
// Clear and empty-table sample go straight to S_DONE; insert scans for its slot, shifts later entries up, then writes.
// Sample: optional loop wrap divide, scan of entries, two row reads, 49-step fraction divide, then 10 lerps;
// with no segment hit, or with one entry, the row read is returned without the divide.
// One command at a time: s_ready only in S_IDLE; a result waiting for m_ready stalls only S_DONE.
// Reset (aresetn low, synchronous) empties the table and zeros both config registers.
module keyframe_track_interpolator #(
    parameter int MAX_KEYS  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  kti_pkg::in_word_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output kti_pkg::out_word_t   m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [0:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    import kti_pkg::*;

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int FW = FRAC_BITS + 1;
    localparam int NW = 33 + FRAC_BITS;     // dividend width

    typedef enum logic [3:0] {
        S_IDLE, S_WRAP, S_SCAN_RD, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_INS_WR,
        S_SEG_RD, S_DIV, S_LERP_MUL, S_LERP_ADD, S_DONE
    } state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg;
    logic [DUR_W-1:0] dur_reg;
    logic loop_reg;
    in_word_t in_reg;
    logic [CW-1:0] k_reg;          // scan / shift index
    logic [CW-1:0] pos_reg;
    logic signed [33:0] st_reg;    // clamped sample time
    logic [33:0] rem_reg;          // shared remainder for wrap and fraction
    logic [NW-1:0] quo_reg;
    logic [5:0] step_reg;
    logic signed [VAL_W-1:0] t0_reg;
    logic seg_hit_reg;
    row_t a_reg, b_reg;
    logic [3:0] vi_reg;
    logic signed [VAL_W:0] d_reg;
    logic [FW-1:0] f_reg;
    logic [NUM_VALS*VAL_W-1:0] res_reg;
    logic m_valid_reg;
    out_word_t m_data_reg;
    logic finished_reg;
    logic full_reg;

    // RAM port
    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    row_t ram_wdata, ram_rdata;

    kti_ram #(.WIDTH(NUM_VALS*VAL_W), .DEPTH(MAX_KEYS)) u_rows (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    function automatic logic signed [VAL_W-1:0] fld(row_t r, int i);
        fld = r[(NUM_VALS-1-i)*VAL_W +: VAL_W];
    endfunction

    row_t in_row;
    assign in_row = {in_reg.item_time, in_reg.pos_x, in_reg.pos_y, in_reg.pos_z,
                     in_reg.aim_x, in_reg.aim_y, in_reg.aim_z, in_reg.yaw_in,
                     in_reg.pitch_in, in_reg.fov_in};

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // read address: scan index, shift source k-1, segment read k then k+1
    logic signed [VAL_W-1:0] rtime;
    assign rtime = fld(ram_rdata, 0);

    // divider step (restoring, one bit a cycle)
    logic [33:0] rem_sh;
    logic [34:0] rem_sub;
    logic [33:0] div_den;
    always_comb begin
        div_den = (state_reg == S_WRAP) ? {3'd0, dur_reg}
                : 34'(fld(b_reg, 0) - t0_reg);
        rem_sh  = {rem_reg[32:0], quo_reg[NW-1]};
        rem_sub = {1'b0, rem_sh} - {1'b0, div_den};
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = k_reg[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = k_reg[AW-1:0];
        case (state_reg)
            S_SHIFT_RD: ram_raddr = AW'(k_reg - CW'(1));
            S_SHIFT_WR: ram_we = 1'b1;
            S_INS_WR: begin
                ram_we = 1'b1;
                ram_waddr = pos_reg[AW-1:0];
                ram_wdata = in_row;
            end
            default: ;
        endcase
    end

    logic signed [VAL_W:0] a_v, b_v;
    assign a_v = fld(a_reg, int'(vi_reg));
    assign b_v = fld(b_reg, int'(vi_reg));

    // (b - a) * f, exact at full width
    logic signed [VAL_W+FW:0] lerp_prod;
    assign lerp_prod = d_reg * $signed({1'b0, f_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            dur_reg     <= '0;
            loop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_DURATION: dur_reg  <= cfg_data[DUR_W-1:0];
                    CFG_LOOP:     loop_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready && state_reg != S_DONE) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready && s_data.cmd != CMD_NONE) begin
                        in_reg <= s_data;
                        k_reg  <= '0;
                        res_reg <= '0;
                        step_reg <= '0;
                        case (s_data.cmd)
                            CMD_INSERT: begin
                                finished_reg <= 1'b0;
                                state_reg <= S_SCAN_RD;
                            end
                            CMD_CLEAR: begin
                                finished_reg <= 1'b0;
                                count_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            default: begin
                                finished_reg <= !loop_reg &&
                                    ($signed({s_data.item_time[31], s_data.item_time})
                                     >= $signed({2'b0, dur_reg}));
                                st_reg <= 34'(s_data.item_time);
                                // wrap: |t| through divider, sign fixed later
                                rem_reg <= '0;
                                quo_reg <= NW'(s_data.item_time[31]
                                    ? -{1'b0, s_data.item_time} : {1'b0, s_data.item_time})
                                    << (NW - 32);
                                if (count_reg == '0) state_reg <= S_DONE;
                                else if (loop_reg && dur_reg != '0) state_reg <= S_WRAP;
                                else state_reg <= S_SCAN_RD;
                            end
                        endcase
                    end
                end
                S_WRAP: begin
                    if (!rem_sub[34]) rem_reg <= rem_sub[33:0];
                    else rem_reg <= rem_sh;
                    quo_reg <= quo_reg << 1;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd31) begin
                        // negative time gives negative remainder -> clamp to 0
                        st_reg <= in_reg.item_time[31] ? 34'sd0
                            : $signed({1'b0, (!rem_sub[34] ? rem_sub[32:0] : rem_sh[32:0])});
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: begin
                    // clamp sample time (no-op for inserts)
                    if (st_reg > $signed({3'b0, dur_reg})) st_reg <= {3'b0, dur_reg};
                    else if (st_reg < 0) st_reg <= '0;
                    if (in_reg.cmd == CMD_INSERT && count_reg >= CW'(MAX_KEYS)) begin
                        state_reg <= S_DONE;
                    end else if (in_reg.cmd == CMD_INSERT && count_reg == '0) begin
                        pos_reg <= '0;
                        state_reg <= S_INS_WR;
                    end else if (in_reg.cmd != CMD_INSERT && count_reg == CW'(1)) begin
                        seg_hit_reg <= 1'b0;
                        k_reg <= '0;
                        step_reg <= '0;
                        state_reg <= S_SEG_RD;
                    end else begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // rdata holds entry k_reg; address moves to k_reg+1
                    if (in_reg.cmd == CMD_INSERT) begin
                        if (rtime > in_reg.item_time) begin
                            pos_reg <= k_reg;
                            k_reg <= count_reg;
                            state_reg <= (count_reg == k_reg) ? S_INS_WR : S_SHIFT_RD;
                        end else if (k_reg + CW'(1) == count_reg) begin
                            pos_reg <= count_reg;
                            state_reg <= S_INS_WR;
                        end else begin
                            k_reg <= k_reg + CW'(1);
                            state_reg <= S_SCAN_RD;
                        end
                    end else begin
                        // sample: seg k-1 valid if st in [t_k-1, t_k]
                        if (k_reg != '0 && st_reg >= 34'(t0_reg) && st_reg <= 34'(rtime)) begin
                            seg_hit_reg <= 1'b1;
                            k_reg <= k_reg - CW'(1);
                            step_reg <= '0;
                            state_reg <= S_SEG_RD;
                        end else if (k_reg + CW'(1) == count_reg) begin
                            seg_hit_reg <= 1'b0;
                            step_reg <= '0;
                            state_reg <= S_SEG_RD;
                        end else begin
                            t0_reg <= rtime;
                            k_reg <= k_reg + CW'(1);
                            state_reg <= S_SCAN_RD;
                        end
                    end
                end
                S_SHIFT_RD: state_reg <= S_SHIFT_WR;
                S_SHIFT_WR: begin
                    k_reg <= k_reg - CW'(1);
                    state_reg <= (k_reg - CW'(1) == pos_reg) ? S_INS_WR : S_SHIFT_RD;
                end
                S_INS_WR: begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_DONE;
                end
                S_SEG_RD: begin
                    // two reads: entry k then k+1 (step_reg as phase)
                    case (step_reg[1:0])
                        2'd0: begin
                            step_reg <= step_reg + 6'd1;
                            if (seg_hit_reg) k_reg <= k_reg + CW'(1);
                            else k_reg <= count_reg - CW'(1);
                        end
                        2'd1: begin
                            step_reg <= step_reg + 6'd1;
                            a_reg <= ram_rdata;
                        end
                        default: begin
                            b_reg <= ram_rdata;
                            if (!seg_hit_reg) begin
                                res_reg <= ram_rdata;
                                state_reg <= S_DONE;
                            end else begin
                                t0_reg <= fld(a_reg, 0);
                                rem_reg <= '0;
                                quo_reg <= NW'(st_reg - 34'(fld(a_reg, 0))) << FRAC_BITS;
                                step_reg <= '0;
                                state_reg <= S_DIV;
                            end
                        end
                    endcase
                end
                S_DIV: begin
                    if (!rem_sub[34]) begin
                        rem_reg <= rem_sub[33:0];
                        quo_reg <= {quo_reg[NW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[NW-2:0], 1'b0};
                    end
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(NW - 1)) begin
                        vi_reg <= '0;
                        state_reg <= S_LERP_MUL;
                    end
                end
                S_LERP_MUL: begin
                    if (vi_reg == '0)
                        f_reg <= (div_den == '0) ? '0 : quo_reg[FW-1:0];
                    d_reg <= b_v - a_v;
                    state_reg <= S_LERP_ADD;
                end
                S_LERP_ADD: begin
                    res_reg[(NUM_VALS-1-int'(vi_reg))*VAL_W +: VAL_W] <=
                        VAL_W'(a_v + 33'(lerp_prod >>> FRAC_BITS));
                    vi_reg <= vi_reg + 4'd1;
                    state_reg <= (vi_reg == 4'(NUM_VALS - 1)) ? S_DONE : S_LERP_MUL;
                end
                S_DONE: begin
                    // hold here while the previous word still waits in the output register
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg.finished <= finished_reg;
                        {m_data_reg.out_time, m_data_reg.out_pos_x, m_data_reg.out_pos_y,
                         m_data_reg.out_pos_z, m_data_reg.out_aim_x, m_data_reg.out_aim_y,
                         m_data_reg.out_aim_z, m_data_reg.out_yaw, m_data_reg.out_pitch,
                         m_data_reg.out_fov} <= res_reg;
                        case (in_reg.cmd)
                            CMD_INSERT: m_data_reg.status <= full_reg ? ST_FULL : ST_INSERT_OK;
                            CMD_CLEAR:  m_data_reg.status <= ST_INSERT_OK;
                            default:    m_data_reg.status <= (count_reg == '0) ? ST_EMPTY
                                                                             : ST_SAMPLE_OK;
                        endcase
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // table was full when the insert was accepted
    always_ff @(posedge aclk) begin
        if (!aresetn) full_reg <= 1'b0;
        else if (state_reg == S_IDLE) full_reg <= (count_reg >= CW'(MAX_KEYS));
    end
endmodule
